// ===== sv/bps_pkg.sv =====
// bps_pkg: shared constants, types and arithmetic helpers of the blinn-phong shader
// used by bps_unitize and blinn_phong_light_shader_unit; no dependencies
package bps_pkg;

    // widths of the vector formats
    localparam int VEC_W  = 33;   // signed vector component fed to normalization
    localparam int UNIT_W = 16;   // signed unit component, q2.14
    localparam int Q14_W  = 15;   // unsigned cosine or power, q1.14, up to 1.0
    localparam int CH_W   = 8;    // colour channel
    localparam int COL_W  = 10;   // summed colour channel

    localparam logic [Q14_W-1:0] ONE_Q14 = 15'd16384;

    // pipeline depth of one normalization unit
    localparam int UNIT_LAT = 53;

    // shading modes
    localparam logic [1:0] MODE_SPEC_ADD = 2'd1;
    localparam logic [1:0] MODE_SPEC_SEP = 2'd2;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_KIND = 3'd0,
        REG_AMB  = 3'd1,
        REG_DIF  = 3'd2,
        REG_SPC  = 3'd3,
        REG_VX   = 3'd4,
        REG_VY   = 3'd5,
        REG_VZ   = 3'd6,
        REG_THR  = 3'd7
    } t_reg_idx;

    localparam logic [23:0] RST_AMB = 24'h000000;
    localparam logic [23:0] RST_DIF = 24'hFFFFFF;
    localparam logic [23:0] RST_SPC = 24'hFFFFFF;
    localparam logic [7:0]  RST_THR = 8'd16;

    // colour product, rounded a*b/255
    function automatic logic [CH_W-1:0] mul8(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
        logic [16:0] p;
        logic [16:0] s;
        p = 17'(a) * 17'(b) + 17'd128;
        s = p + (p >> 8);
        return s[15:8];
    endfunction

    // colour times q1.14 factor, rounded
    function automatic logic [CH_W-1:0] term(input logic [CH_W-1:0] c, input logic [Q14_W-1:0] f);
        logic [22:0] p;
        p = 23'(c) * 23'(f) + 23'd8192;
        return p[21:14];
    endfunction

    // q1.14 product, rounded
    function automatic logic [Q14_W-1:0] rnd_q14(input logic [Q14_W-1:0] a,
                                                 input logic [Q14_W-1:0] b);
        logic [29:0] p;
        p = 30'(a) * 30'(b) + 30'd8192;
        return p[28:14];
    endfunction

    // q5.28 dot product to clamped q1.14 cosine
    function automatic logic [Q14_W-1:0] cos_sat(input logic signed [32:0] d);
        logic [18:0] c;
        c = d[32:14];
        if (d <= 0) begin
            return '0;
        end else if (c > 19'(ONE_Q14)) begin
            return ONE_Q14;
        end else begin
            return c[Q14_W-1:0];
        end
    endfunction

endpackage

// ===== sv/blinn_phong_light_shader_unit.sv =====
// blinn_phong_light_shader_unit: top level of the fixed-point blinn-phong shader
// depends on bps_pkg and bps_unitize
// throughput: one word per cycle while the output queue has room, set by the fully pipelined
// datapath (two 53-stage normalization units in series, eight squaring stages for the exponent)
// reset: synchronous active-low i_rst_n clears the pipeline valid bits, the output
// queue and the light registers (kind 0, ambient 0, diffuse and specular white, threshold 16)
module blinn_phong_light_shader_unit
    import bps_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // point_x, point_y, point_z, normal_x, normal_y, normal_z,
    // mat_ambient_rgb, mat_diffuse_rgb, mat_specular_rgb, shininess
    input  logic [223:0] s_axis_tdata,
    // mode
    input  logic [1:0]   s_axis_tuser,
    // master side
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // color_r, color_g, color_b, spec_r, spec_g, spec_b, 2 zero bits
    output logic [55:0]  m_axis_tdata,
    // configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // stage map: 0 input register, light and view normalization end at UNIT_LAT,
    // dot products, diffuse cosine, halfway normalization, halfway cosine,
    // eight squaring steps, colour terms, final sum
    localparam int ST_DOT   = UNIT_LAT + 1;
    localparam int ST_CD    = UNIT_LAT + 2;
    localparam int ST_HDOT  = 2 * UNIT_LAT + 2;
    localparam int ST_CS    = 2 * UNIT_LAT + 3;
    localparam int ST_PW    = ST_CS + 1;
    localparam int PW_N     = 8;
    localparam int ST_TERM  = ST_PW + PW_N;
    localparam int ST_LAST  = ST_TERM + 1;
    localparam int OUT_W    = 3 * COL_W + 3 * CH_W;

    // per-word side data that rides along the pipeline
    typedef struct packed {
        logic [1:0]             mode;
        logic [2:0][UNIT_W-1:0] n;
        logic [7:0]             sh;
        logic [2:0][CH_W-1:0]   amb;
        logic [2:0][CH_W-1:0]   dcol;
        logic [2:0][CH_W-1:0]   scol;
        logic [Q14_W-1:0]       cd;
        logic                   dif;
        logic [Q14_W-1:0]       cs;
        logic                   csok;
        logic [Q14_W-1:0]       pr;
        logic [Q14_W-1:0]       pb;
    } t_side;

    // light registers
    logic               r_kind;
    logic [23:0]        r_amb, r_dif, r_spc;
    logic [31:0]        r_lvx, r_lvy, r_lvz;
    logic [7:0]         r_thr;

    // pipeline control
    logic [ST_LAST:0]   r_vld;
    logic               w_adv;

    // stage 0 payload
    logic [2:0][31:0]   r_pt;
    logic [2:0][23:0]   r_mat;

    t_side              r_side [ST_TERM+1];
    t_side              n_side [ST_TERM+1];

    // normalization units
    logic [2:0][VEC_W-1:0]  w_lv, w_nv, w_hv;
    logic [2:0][UNIT_W-1:0] w_lu, w_vu, w_hu;
    logic                   w_lok, w_vok, w_hok;

    // dot product stages
    logic [2:0][VEC_W-1:0]  r_h;
    logic [2:0][31:0]       r_pl, r_ph;
    logic                   r_lok, r_hok;

    // term and output stages
    logic [2:0][CH_W-1:0]   r_tdif, r_tspc;
    logic [2:0][COL_W-1:0]  r_col;
    logic [2:0][CH_W-1:0]   r_so;

    // output queue, two words
    logic [OUT_W-1:0]       r_fifo [2];
    logic                   r_wp, r_rp;
    logic [1:0]             r_cnt;
    logic                   w_push, w_pop;

    // ---------------------------------------------------------------- config port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= 1'b0;
            r_amb  <= RST_AMB;
            r_dif  <= RST_DIF;
            r_spc  <= RST_SPC;
            r_lvx  <= '0;
            r_lvy  <= '0;
            r_lvz  <= '0;
            r_thr  <= RST_THR;
        end else if (psel && penable && pwrite) begin
            case (t_reg_idx'(paddr[4:2]))
                REG_KIND: r_kind <= pwdata[0];
                REG_AMB:  r_amb  <= pwdata[23:0];
                REG_DIF:  r_dif  <= pwdata[23:0];
                REG_SPC:  r_spc  <= pwdata[23:0];
                REG_VX:   r_lvx  <= pwdata;
                REG_VY:   r_lvy  <= pwdata;
                REG_VZ:   r_lvz  <= pwdata;
                REG_THR:  r_thr  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[4:2]))
            REG_KIND: prdata = 32'(r_kind);
            REG_AMB:  prdata = 32'(r_amb);
            REG_DIF:  prdata = 32'(r_dif);
            REG_SPC:  prdata = 32'(r_spc);
            REG_VX:   prdata = r_lvx;
            REG_VY:   prdata = r_lvy;
            REG_VZ:   prdata = r_lvz;
            REG_THR:  prdata = 32'(r_thr);
            default:  prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- pipeline control
    // the whole pipe moves together while the output queue has room; a word in the
    // queue does not block new input until both slots are taken
    assign w_adv         = (r_cnt != 2'd2);
    assign s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[ST_LAST-1:0], s_axis_tvalid};
        end
    end

    // ---------------------------------------------------------------- light and view vectors
    always_comb begin
        logic [2:0][31:0] lsrc;
        lsrc = {r_lvz, r_lvy, r_lvx};
        for (int i = 0; i < 3; i++) begin
            if (r_kind) begin
                w_lv[i] = VEC_W'($signed(lsrc[i]));
            end else begin
                w_lv[i] = VEC_W'($signed(lsrc[i])) - VEC_W'($signed(r_pt[i]));
            end
            w_nv[i] = VEC_W'(0) - VEC_W'($signed(r_pt[i]));
        end
    end

    bps_unitize u_light (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_v   (w_lv),
        .o_u   (w_lu),
        .o_ok  (w_lok)
    );

    bps_unitize u_view (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_v   (w_nv),
        .o_u   (w_vu),
        .o_ok  (w_vok)
    );

    // halfway vector, zero view when the point sits at the camera
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_hv[i] = r_h[i];
        end
    end

    bps_unitize u_half (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_v   (w_hv),
        .o_u   (w_hu),
        .o_ok  (w_hok)
    );

    // ---------------------------------------------------------------- side data
    always_comb begin
        logic signed [32:0] dsum;
        logic [3:0]         pidx;
        dsum = '0;
        pidx = '0;
        n_side[0].mode = s_axis_tuser;
        n_side[0].n    = s_axis_tdata[143:96];
        n_side[0].sh   = s_axis_tdata[223:216];
        n_side[0].amb  = '0;
        n_side[0].dcol = '0;
        n_side[0].scol = '0;
        n_side[0].cd   = '0;
        n_side[0].dif  = 1'b0;
        n_side[0].cs   = '0;
        n_side[0].csok = 1'b0;
        n_side[0].pr   = '0;
        n_side[0].pb   = '0;
        for (int k = 1; k <= ST_TERM; k++) begin
            n_side[k] = r_side[k-1];
            // colour products, channel 0 is red
            if (k == 1) begin
                for (int i = 0; i < 3; i++) begin
                    n_side[k].amb[i]  = mul8(r_mat[0][8*(2-i) +: 8], r_amb[8*(2-i) +: 8]);
                    n_side[k].dcol[i] = mul8(r_mat[1][8*(2-i) +: 8], r_dif[8*(2-i) +: 8]);
                    n_side[k].scol[i] = mul8(r_mat[2][8*(2-i) +: 8], r_spc[8*(2-i) +: 8]);
                end
            end
            // diffuse cosine
            if (k == ST_CD) begin
                dsum = 33'($signed(r_pl[0])) + 33'($signed(r_pl[1])) + 33'($signed(r_pl[2]));
                n_side[k].cd  = r_lok ? cos_sat(dsum) : '0;
                n_side[k].dif = r_lok && (cos_sat(dsum) > 15'(r_thr));
            end
            // halfway cosine, seeds the exponent pipeline
            if (k == ST_CS) begin
                dsum = 33'($signed(r_ph[0])) + 33'($signed(r_ph[1])) + 33'($signed(r_ph[2]));
                n_side[k].cs   = r_hok ? cos_sat(dsum) : '0;
                n_side[k].csok = r_hok && (cos_sat(dsum) > 15'(r_thr));
                n_side[k].pr   = ONE_Q14;
                n_side[k].pb   = r_hok ? cos_sat(dsum) : '0;
            end
            // one exponent bit per stage, lsb first
            if (k >= ST_PW && k < ST_PW + PW_N) begin
                pidx = 4'(k - ST_PW);
                if (r_side[k-1].sh[pidx[2:0]]) begin
                    n_side[k].pr = rnd_q14(r_side[k-1].pr, r_side[k-1].pb);
                end
                n_side[k].pb = rnd_q14(r_side[k-1].pb, r_side[k-1].pb);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic spec;
        if (w_adv) begin
            r_pt  <= s_axis_tdata[95:0];
            r_mat <= {s_axis_tdata[215:192], s_axis_tdata[191:168], s_axis_tdata[167:144]};
            for (int k = 0; k <= ST_TERM; k++) begin
                r_side[k] <= n_side[k];
            end

            // light and halfway dot products, halfway sum
            for (int i = 0; i < 3; i++) begin
                r_pl[i] <= 32'($signed(w_lu[i])) * 32'($signed(r_side[UNIT_LAT].n[i]));
                r_h[i]  <= VEC_W'($signed(w_lu[i])) +
                           (w_vok ? VEC_W'($signed(w_vu[i])) : VEC_W'(0));
                r_ph[i] <= 32'($signed(w_hu[i])) * 32'($signed(r_side[ST_HDOT-1].n[i]));
            end
            r_lok <= w_lok;
            r_hok <= w_hok;

            // specular only with diffuse light, a specular mode and both tests passed
            spec = r_side[ST_TERM-1].dif && r_side[ST_TERM-1].csok &&
                   (r_side[ST_TERM-1].pr > 15'(r_thr)) &&
                   ((r_side[ST_TERM-1].mode == MODE_SPEC_ADD) ||
                    (r_side[ST_TERM-1].mode == MODE_SPEC_SEP));
            for (int i = 0; i < 3; i++) begin
                r_tdif[i] <= r_side[ST_TERM-1].dif ?
                             term(r_side[ST_TERM-1].dcol[i], r_side[ST_TERM-1].cd) : '0;
                r_tspc[i] <= spec ? term(r_side[ST_TERM-1].scol[i], r_side[ST_TERM-1].pr) : '0;
            end

            // final colour and separate specular
            for (int i = 0; i < 3; i++) begin
                r_col[i] <= COL_W'(r_side[ST_TERM].amb[i]) + COL_W'(r_tdif[i]) +
                            ((r_side[ST_TERM].mode == MODE_SPEC_ADD) ? COL_W'(r_tspc[i]) : '0);
                r_so[i]  <= (r_side[ST_TERM].mode == MODE_SPEC_SEP) ? r_tspc[i] : '0;
            end
        end
    end

    // ---------------------------------------------------------------- output queue
    assign w_push = w_adv && r_vld[ST_LAST];
    assign w_pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wp] <= {r_so, r_col};
        end
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {2'b00, r_fifo[r_rp]};

    // ---------------------------------------------------------------- checks
    // a finished word stalled at the queue input is held, not dropped
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_LAST] && !w_adv) |=> r_vld[ST_LAST])
        else $error("stalled result lost at the last stage");

    // the queue never holds more than two words
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |=> (r_cnt != 2'd3))
        else $error("output queue overflow");

    // summed colour stays within three full channels
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[9:0] <= 10'd765) &&
                           (m_axis_tdata[19:10] <= 10'd765) &&
                           (m_axis_tdata[29:20] <= 10'd765)))
        else $error("colour channel out of range");

endmodule

// ===== sv/bps_unitize.sv =====
// bps_unitize: pipelined vector normalization (scale, square sum, bitwise square root,
// restoring division per component); depends on bps_pkg
module bps_unitize
    import bps_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [2:0][VEC_W-1:0]        i_v,
    output logic [2:0][UNIT_W-1:0]       o_u,
    output logic                         o_ok
);

    localparam int SQ_N    = 32;
    localparam int DIV_N   = 15;
    localparam int MSB_TGT = 29;

    // stage a: magnitudes
    logic [2:0][VEC_W-1:0] r_a_mag, n_a_mag;
    logic [2:0]            r_a_neg;
    logic [VEC_W-1:0]      r_a_max, n_a_max;
    // stage b: leading one
    logic [2:0][VEC_W-1:0] r_b_mag;
    logic [2:0]            r_b_neg;
    logic [5:0]            r_b_msb, n_b_msb;
    logic                  r_b_zero;
    // stage c: scaled magnitudes
    logic [2:0][29:0]      r_c_m, n_c_m;
    logic [2:0]            r_c_neg;
    logic                  r_c_zero;
    // stage d: squares
    logic [2:0][59:0]      r_d_sq;
    logic [2:0][29:0]      r_d_m;
    logic [2:0]            r_d_neg;
    logic                  r_d_zero;
    // stage e: sum of squares
    logic [61:0]           r_e_sum;
    logic [2:0][29:0]      r_e_m;
    logic [2:0]            r_e_neg;
    logic                  r_e_zero;
    // square root, one result bit per stage
    logic [63:0]           r_s_v [SQ_N];
    logic [63:0]           r_s_r [SQ_N];
    logic [63:0]           n_s_v [SQ_N];
    logic [63:0]           n_s_r [SQ_N];
    logic [2:0][29:0]      r_s_m [SQ_N];
    logic [2:0]            r_s_neg [SQ_N];
    logic                  r_s_zero [SQ_N];
    // division, one quotient bit per stage
    logic [2:0][44:0]      r_q_rem [DIV_N];
    logic [2:0][44:0]      n_q_rem [DIV_N];
    logic [2:0][14:0]      r_q_quo [DIV_N];
    logic [2:0][14:0]      n_q_quo [DIV_N];
    logic [30:0]           r_q_len [DIV_N];
    logic [2:0]            r_q_neg [DIV_N];
    logic                  r_q_zero [DIV_N];
    // output
    logic [2:0][UNIT_W-1:0] r_u, n_u;
    logic                   r_ok;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a_mag[i] = i_v[i][VEC_W-1] ? (~i_v[i] + VEC_W'(1)) : i_v[i];
        end
        n_a_max = n_a_mag[0];
        if (n_a_mag[1] > n_a_max) n_a_max = n_a_mag[1];
        if (n_a_mag[2] > n_a_max) n_a_max = n_a_mag[2];
    end

    always_comb begin
        n_b_msb = '0;
        for (int b = 0; b < VEC_W; b++) begin
            if (r_a_max[b]) n_b_msb = 6'(b);
        end
    end

    // bring the largest magnitude into [2^29, 2^30)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_b_msb > 6'(MSB_TGT)) begin
                n_c_m[i] = 30'(r_b_mag[i] >> (r_b_msb - 6'(MSB_TGT)));
            end else begin
                n_c_m[i] = 30'(r_b_mag[i] << (6'(MSB_TGT) - r_b_msb));
            end
        end
    end

    always_comb begin
        logic [63:0] vi;
        logic [63:0] ri;
        logic [63:0] bb;
        logic [63:0] rb;
        for (int k = 0; k < SQ_N; k++) begin
            vi = (k == 0) ? 64'(r_e_sum) : r_s_v[(k == 0) ? 0 : k-1];
            ri = (k == 0) ? '0 : r_s_r[(k == 0) ? 0 : k-1];
            bb = 64'(1) << (2 * (SQ_N - 1 - k));
            rb = ri + bb;
            if (vi >= rb) begin
                n_s_v[k] = vi - rb;
                n_s_r[k] = (ri >> 1) + bb;
            end else begin
                n_s_v[k] = vi;
                n_s_r[k] = ri >> 1;
            end
        end
    end

    always_comb begin
        logic [30:0] len;
        logic [44:0] dsh;
        logic [2:0][44:0] rem;
        logic [2:0][14:0] quo;
        for (int j = 0; j < DIV_N; j++) begin
            if (j == 0) begin
                len = r_s_r[SQ_N-1][30:0];
                for (int i = 0; i < 3; i++) begin
                    rem[i] = 45'({r_s_m[SQ_N-1][i], 14'd0});
                    quo[i] = '0;
                end
            end else begin
                len = r_q_len[j-1];
                rem = r_q_rem[j-1];
                quo = r_q_quo[j-1];
            end
            dsh = 45'(len) << (DIV_N - 1 - j);
            for (int i = 0; i < 3; i++) begin
                if (rem[i] >= dsh) begin
                    n_q_rem[j][i] = rem[i] - dsh;
                    n_q_quo[j][i] = quo[i] | (15'(1) << (DIV_N - 1 - j));
                end else begin
                    n_q_rem[j][i] = rem[i];
                    n_q_quo[j][i] = quo[i];
                end
            end
        end
    end

    always_comb begin
        logic [UNIT_W-1:0] q;
        for (int i = 0; i < 3; i++) begin
            q = UNIT_W'(r_q_quo[DIV_N-1][i]);
            if (r_q_zero[DIV_N-1]) begin
                n_u[i] = '0;
            end else if (r_q_neg[DIV_N-1][i]) begin
                n_u[i] = ~q + UNIT_W'(1);
            end else begin
                n_u[i] = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mag  <= n_a_mag;
            r_a_max  <= n_a_max;
            for (int i = 0; i < 3; i++) r_a_neg[i] <= i_v[i][VEC_W-1];

            r_b_mag  <= r_a_mag;
            r_b_neg  <= r_a_neg;
            r_b_msb  <= n_b_msb;
            r_b_zero <= (r_a_max == '0);

            r_c_m    <= n_c_m;
            r_c_neg  <= r_b_neg;
            r_c_zero <= r_b_zero;

            for (int i = 0; i < 3; i++) r_d_sq[i] <= 60'(r_c_m[i]) * 60'(r_c_m[i]);
            r_d_m    <= r_c_m;
            r_d_neg  <= r_c_neg;
            r_d_zero <= r_c_zero;

            r_e_sum  <= 62'(r_d_sq[0]) + 62'(r_d_sq[1]) + 62'(r_d_sq[2]);
            r_e_m    <= r_d_m;
            r_e_neg  <= r_d_neg;
            r_e_zero <= r_d_zero;

            for (int k = 0; k < SQ_N; k++) begin
                r_s_v[k] <= n_s_v[k];
                r_s_r[k] <= n_s_r[k];
                if (k == 0) begin
                    r_s_m[k]    <= r_e_m;
                    r_s_neg[k]  <= r_e_neg;
                    r_s_zero[k] <= r_e_zero;
                end else begin
                    r_s_m[k]    <= r_s_m[k-1];
                    r_s_neg[k]  <= r_s_neg[k-1];
                    r_s_zero[k] <= r_s_zero[k-1];
                end
            end

            for (int j = 0; j < DIV_N; j++) begin
                r_q_rem[j] <= n_q_rem[j];
                r_q_quo[j] <= n_q_quo[j];
                if (j == 0) begin
                    r_q_len[j]  <= r_s_r[SQ_N-1][30:0];
                    r_q_neg[j]  <= r_s_neg[SQ_N-1];
                    r_q_zero[j] <= r_s_zero[SQ_N-1];
                end else begin
                    r_q_len[j]  <= r_q_len[j-1];
                    r_q_neg[j]  <= r_q_neg[j-1];
                    r_q_zero[j] <= r_q_zero[j-1];
                end
            end

            r_u  <= n_u;
            r_ok <= !r_q_zero[DIV_N-1];
        end
    end

    assign o_u  = r_u;
    assign o_ok = r_ok;

endmodule

// ===== tb/sv/tb_blinn_phong_light_shader_unit.sv =====
// tb_blinn_phong_light_shader_unit: self-checking stream testbench of the blinn-phong shader
// depends on bps_pkg and blinn_phong_light_shader_unit; predicts every result word in place
`timescale 1ns / 100ps
module tb_blinn_phong_light_shader_unit
    import bps_pkg::*;
();

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] px, py, pz;
        logic [15:0] nx, ny, nz;
        logic [23:0] ma, md, ms;
        logic [7:0]  sh;
    } t_pixel;

    typedef struct packed {
        logic [9:0] cr, cg, cb;
        logic [7:0] sr, sg, sb;
    } t_shade;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [223:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [55:0]  m_axis_tdata;
    logic         psel, penable, pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    blinn_phong_light_shader_unit u_top (.*);

    // light state as the predictor sees it
    logic        lt_kind;
    logic [23:0] lt_amb, lt_dif, lt_spc;
    logic signed [63:0] lt_vec [3];
    logic [7:0]  lt_thr;

    t_pixel pixel_q [$];      // words waiting for the driver
    t_shade shade_q [$];      // predicted results, oldest first
    int     mismatches = 0;
    bit     input_idle_off = 0;
    bit     output_idle_off = 0;
    bit     long_hold = 0;
    longint cycles = 0;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // integer square root, bit by bit
    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // scale to [2^29, 2^30) then divide by the length; returns 0 on a zero vector
    function automatic bit to_unit(input logic signed [63:0] v [3],
                                   output logic signed [63:0] u [3]);
        logic [63:0] m [3];
        logic [63:0] mx, len;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i] < 0 ? -v[i] : v[i];
            u[i] = 0;
        end
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        if (mx == 0) return 0;
        while (mx >= 64'd1 << 30) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (mx < 64'd1 << 29) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        len = isqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++) begin
            u[i] = (m[i] << 14) / len;
            if (v[i] < 0) u[i] = -u[i];
        end
        return 1;
    endfunction

    function automatic logic [31:0] dot_cos(input logic signed [63:0] u [3],
                                            input logic signed [63:0] n [3]);
        logic signed [63:0] d;
        d = u[0] * n[0] + u[1] * n[1] + u[2] * n[2];
        if (d <= 0) return 0;
        d = d >>> 14;
        return d > 16384 ? 32'd16384 : d[31:0];
    endfunction

    function automatic logic [31:0] ch_prod(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] p;
        p = a * b + 128;
        return (p + (p >> 8)) >> 8;
    endfunction

    function automatic logic [31:0] scaled(input logic [31:0] c, input logic [31:0] f);
        return (c * f + 8192) >> 14;
    endfunction

    function automatic t_shade shade_pixel(input t_pixel w);
        logic signed [63:0] p [3], n [3], lv [3], lu [3], vv [3], vu [3], h [3], hu [3];
        logic [31:0] cd, pw, cs, e, r, b, col, s;
        logic [31:0] cols [3], specs [3];
        bit dif, spec;
        t_shade o;
        cd = 0;
        pw = 0;
        spec = 0;
        p[0] = $signed(w.px); p[1] = $signed(w.py); p[2] = $signed(w.pz);
        n[0] = $signed(w.nx); n[1] = $signed(w.ny); n[2] = $signed(w.nz);
        for (int i = 0; i < 3; i++) lv[i] = lt_kind ? lt_vec[i] : lt_vec[i] - p[i];
        if (to_unit(lv, lu)) cd = dot_cos(lu, n);
        dif = cd > lt_thr;
        if (dif && (w.mode == MODE_SPEC_ADD || w.mode == MODE_SPEC_SEP)) begin
            for (int i = 0; i < 3; i++) vv[i] = -p[i];
            void'(to_unit(vv, vu));
            for (int i = 0; i < 3; i++) h[i] = vu[i] + lu[i];
            if (to_unit(h, hu)) begin
                cs = dot_cos(hu, n);
                if (cs > lt_thr) begin
                    // exponent by repeated squaring, rounded at every step
                    r = 16384;
                    b = cs;
                    e = 32'(w.sh);
                    while (e != 0) begin
                        if (e[0]) r = (r * b + 8192) >> 14;
                        b = (b * b + 8192) >> 14;
                        e >>= 1;
                    end
                    pw = r;
                    spec = pw > lt_thr;
                end
            end
        end
        for (int k = 0; k < 3; k++) begin
            col = ch_prod(w.ma[23-8*k -: 8], lt_amb[23-8*k -: 8]);
            s = 0;
            if (dif) col += scaled(ch_prod(w.md[23-8*k -: 8], lt_dif[23-8*k -: 8]), cd);
            if (spec) s = scaled(ch_prod(w.ms[23-8*k -: 8], lt_spc[23-8*k -: 8]), pw);
            if (w.mode == MODE_SPEC_ADD) begin
                col += s;
                s = 0;
            end else if (w.mode != MODE_SPEC_SEP) begin
                s = 0;
            end
            cols[k] = col;
            specs[k] = s;
        end
        o.cr = cols[0][9:0]; o.cg = cols[1][9:0]; o.cb = cols[2][9:0];
        o.sr = specs[0][7:0]; o.sg = specs[1][7:0]; o.sb = specs[2][7:0];
        return o;
    endfunction

    // driver: idle bursts on the input side, one word per accepted handshake
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) void'(pixel_q.pop_front());
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the offered word
            end else if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (!input_idle_off && $urandom_range(0, 9) == 0) begin
                in_gap <= $urandom_range(1, 12) - 1;
                s_axis_tvalid <= 1'b0;
            end else begin
                // an accepted word is already popped, so the head is the next one
                if (pixel_q.size() != 0) begin
                    t_pixel w;
                    w = pixel_q[0];
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {w.sh, w.ms, w.md, w.ma, w.nz, w.ny, w.nx,
                                     w.pz, w.py, w.px};
                    s_axis_tuser <= w.mode;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // prediction happens at acceptance, with the light state then in force
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            t_pixel w;
            w.px = s_axis_tdata[31:0];     w.py = s_axis_tdata[63:32];
            w.pz = s_axis_tdata[95:64];    w.nx = s_axis_tdata[111:96];
            w.ny = s_axis_tdata[127:112];  w.nz = s_axis_tdata[143:128];
            w.ma = s_axis_tdata[167:144];  w.md = s_axis_tdata[191:168];
            w.ms = s_axis_tdata[215:192];  w.sh = s_axis_tdata[223:216];
            w.mode = s_axis_tuser;
            shade_q.push_back(shade_pixel(w));
        end
    end

    // receiver stall: random bursts, plus one long hold-off counted here
    int out_gap = 0;
    int hold_cnt = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (long_hold && hold_cnt < 400) begin
            hold_cnt <= hold_cnt + 1;
            m_axis_tready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (!output_idle_off && $urandom_range(0, 7) == 0) begin
            out_gap <= $urandom_range(1, 12) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor: compare every result word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_shade got, want;
            got.cr = m_axis_tdata[9:0];   got.cg = m_axis_tdata[19:10];
            got.cb = m_axis_tdata[29:20]; got.sr = m_axis_tdata[37:30];
            got.sg = m_axis_tdata[45:38]; got.sb = m_axis_tdata[53:46];
            if (shade_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", m_axis_tdata);
            end else begin
                want = shade_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("shade mismatch: exp c=%0d/%0d/%0d s=%0d/%0d/%0d %s",
                                 want.cr, want.cg, want.cb, want.sr, want.sg, want.sb,
                                 $sformatf("got c=%0d/%0d/%0d s=%0d/%0d/%0d",
                                           got.cr, got.cg, got.cb,
                                           got.sr, got.sg, got.sb));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_KIND: lt_kind = val[0];
            REG_AMB:  lt_amb = val[23:0];
            REG_DIF:  lt_dif = val[23:0];
            REG_SPC:  lt_spc = val[23:0];
            REG_VX:   lt_vec[0] = $signed(val);
            REG_VY:   lt_vec[1] = $signed(val);
            REG_VZ:   lt_vec[2] = $signed(val);
            REG_THR:  lt_thr = val[7:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pixel_q.size() != 0 || s_axis_tvalid || shade_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_normal();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'(0);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'(0);
            3: return $urandom;
            default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
        endcase
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel w;
        w.mode = $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
        w.px = rand_pos();
        w.py = rand_pos();
        // mostly in front of the camera so the light and view meet the surface
        w.pz = $urandom_range(0, 3) == 0 ? rand_pos() : -32'($urandom_range(1 << 16, 50 << 16));
        w.nx = rand_normal();
        w.ny = rand_normal();
        w.nz = $urandom_range(0, 1) ? 16'(16384 - $urandom_range(0, 6000)) : rand_normal();
        w.ma = 24'($urandom);
        w.md = 24'($urandom);
        w.ms = 24'($urandom);
        w.sh = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 40));
        return w;
    endfunction

    task automatic random_batch(input int cnt);
        for (int i = 0; i < cnt; i++) pixel_q.push_back(rand_pixel());
    endtask

    initial begin
        t_pixel w;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        lt_kind = 0;
        lt_amb = RST_AMB;
        lt_dif = RST_DIF;
        lt_spc = RST_SPC;
        lt_vec[0] = 0; lt_vec[1] = 0; lt_vec[2] = 0;
        lt_thr = RST_THR;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset light sits at the camera, then a light above the scene
        w = '0;
        w.pz = -32'(5 << 16); w.nz = 16'sd16384; w.ma = 24'hFFFFFF; w.md = 24'hFFFFFF;
        w.ms = 24'hFFFFFF; w.sh = 8'd1; w.mode = MODE_SPEC_SEP;
        pixel_q.push_back(w);
        // point at the camera, light at the point
        w.pz = 0;
        pixel_q.push_back(w);
        drain();
        reg_write(REG_AMB, 32'hFFFFFF);
        reg_write(REG_VZ, 32'h00050000);
        reg_write(REG_THR, 32'd0);
        for (int m = 0; m < 4; m++) begin
            w = '0;
            w.mode = 2'(m);
            w.pz = -32'(2 << 16);
            w.nz = 16'sd16384;
            w.ma = 24'hFFFFFF; w.md = 24'hFFFFFF; w.ms = 24'hFFFFFF;
            w.sh = m == 0 ? 8'd0 : 8'd255;
            pixel_q.push_back(w);
            w.nz = -16'sd16384; w.nx = 16'sd16384;
            pixel_q.push_back(w);
        end
        // extremes of positions, non-unit normal, zero shininess, light at the point
        w = '0;
        w.mode = MODE_SPEC_ADD;
        w.px = 32'h7FFFFFFF; w.py = 32'h80000000; w.pz = 32'h80000000;
        w.nx = 16'sd16384; w.ny = 16'sd16384; w.nz = 16'sd16384;
        w.ma = 24'hFFFFFF; w.md = 24'hFFFFFF; w.ms = 24'hFFFFFF; w.sh = 8'd255;
        pixel_q.push_back(w);
        w.px = 0; w.py = 0; w.pz = 32'h00050000; w.sh = 8'd0;
        pixel_q.push_back(w);
        w.pz = 32'h00020000; w.nx = -16'sd16384; w.ny = -16'sd16384; w.nz = 16'sd16384;
        w.sh = 8'd128;
        pixel_q.push_back(w);
        drain();

        // directional light with a long vector, then a zero direction
        reg_write(REG_KIND, 32'd1);
        reg_write(REG_VX, 32'h7FFFFFFF);
        reg_write(REG_VY, 32'h80000000);
        reg_write(REG_VZ, 32'h7FFFFFFF);
        reg_write(REG_DIF, 32'h0);
        reg_write(REG_SPC, 32'h123456);
        reg_write(REG_THR, 32'd255);
        random_batch(100);
        drain();
        reg_write(REG_VX, 32'd0); reg_write(REG_VY, 32'd0); reg_write(REG_VZ, 32'd0);
        random_batch(20);
        drain();

        // random light settings, point and directional
        for (int ph = 0; ph < 6; ph++) begin
            reg_write(REG_KIND, $urandom_range(0, 1));
            reg_write(REG_AMB, $urandom);
            reg_write(REG_DIF, $urandom_range(0, 2) == 0 ? 32'hFFFFFF : $urandom);
            reg_write(REG_SPC, $urandom_range(0, 2) == 0 ? 32'hFFFFFF : $urandom);
            reg_write(REG_VX, ph == 5 ? 32'h80000000 :
                      32'($signed($urandom_range(0, 40 << 16)) - (20 << 16)));
            reg_write(REG_VY, ph == 5 ? 32'h7FFFFFFF : 32'($urandom_range(0, 30 << 16)));
            reg_write(REG_VZ, $urandom_range(0, 3) == 0 ? $urandom :
                      32'($urandom_range(0, 20 << 16)));
            reg_write(REG_THR, ph == 0 ? 0 : (ph == 1 ? 255 : $urandom_range(0, 64)));
            if (ph == 2) long_hold = 1;
            if (ph == 5) begin
                input_idle_off = 1;
                output_idle_off = 1;
            end
            random_batch(160);
            drain();
        end

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bps_pkg.sv
sv/bps_unitize.sv
sv/blinn_phong_light_shader_unit.sv
tb/sv/tb_blinn_phong_light_shader_unit.sv
